@@ hdl/dbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbe_pkg
// Shared types and constants of the deque/bag engine: op and status codes,
// field widths of the request and response beats, and cell control.
// ----------------------------------------------------------------------------
package dbe_pkg;

	// fixed field widths of the channel payloads
	localparam int OP_W     = 3;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// defaults for the top-level parameters
	localparam int DEF_DEPTH       = 16;
	localparam int DEF_VALUE_WIDTH = 32;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_CONTAINS   = 3'd4,
		OP_REMOVE     = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// broadcast to every cell; at most one update strobe high in a cycle
	typedef struct packed {
		logic compare;     // latch the match flag against the key
		logic push_front;  // shift toward the back, key enters cell 0
		logic push_back;   // first free cell takes the key
		logic pop_front;   // shift toward the front
		logic pop_back;    // last occupied cell frees itself
		logic remove;      // shift toward the front from the first match on
	} cell_ctrl_t;

endpackage

@@ hdl/dbe_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbe_req_if
// Request channel: op code and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dbe_req_if
	import dbe_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] data_value;

	modport source (output valid, op, data_value, input ready);
	modport sink   (input valid, op, data_value, output ready);
endinterface

@@ hdl/dbe_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbe_rsp_if
// Response channel: status, found flag, ends of the deque and fill level.
// ----------------------------------------------------------------------------
interface dbe_rsp_if
	import dbe_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic                     found;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic [COUNT_W-1:0]       entry_count;
	logic                     is_empty;

	modport source (output valid, status, found, front_value, back_value, entry_count,
		is_empty, input ready);
	modport sink   (input valid, status, found, front_value, back_value, entry_count,
		is_empty, output ready);
endinterface

@@ hdl/deque_bag_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_bag_engine
// Bounded double-ended queue with search and remove-first-match, built as a
// chain of cells.
// ----------------------------------------------------------------------------
// Each request beat runs in three internal steps: the key is broadcast and
// every cell compares it with its value, then the chain shifts or fills
// (the first-match flag ripples from cell to cell), then the ends and the
// count are read out into the response register. A request is taken only
// in the idle state, so a new one waits until the last has been read out;
// the readout step waits while an earlier response is still held, so the next
// request can be taken while a response sits unclaimed. Pushes while full
// report FULL, pops and removes while empty report EMPTY, and neither
// changes the contents. Values are sign-extended or cut to VALUE_WIDTH on
// entry and zero-extended or cut to the 32-bit fields on exit.
// ----------------------------------------------------------------------------
module deque_bag_engine
	import dbe_pkg::*;
#(
	parameter int DEPTH       = DEF_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input logic        clk,
	input logic        arst_n,
	dbe_req_if.sink    req,
	dbe_rsp_if.source  rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_EXEC = 4'b0100,
		S_LOAD = 4'b1000
	} state_t;

	state_t                 state_q;
	op_t                    op_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [CW-1:0]          count_q;
	status_t                status_q;
	logic                   found_q;

	logic                   full;
	logic                   empty;
	logic                   exec;
	logic                   found_c;
	logic                   load;
	cell_ctrl_t             ctrl;

	logic [VALUE_WIDTH-1:0] val_w  [DEPTH+2];
	logic                   occ_w  [DEPTH+2];
	logic                   seen_w [DEPTH+1];
	logic [VALUE_WIDTH-1:0] back_c;
	logic [VALUE_WIDTH-1:0] front_c;

	logic                   rsp_valid_q;
	status_t                rsp_status_q;
	logic                   rsp_found_q;
	logic [VALUE_WIDTH-1:0] rsp_front_q;
	logic [VALUE_WIDTH-1:0] rsp_back_q;
	logic [CW-1:0]          rsp_count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign exec  = (state_q == S_EXEC);
	assign load  = (state_q == S_LOAD) && (!rsp_valid_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (req.valid) state_q <= S_CMP;
				S_CMP:  state_q <= S_EXEC;
				S_EXEC: state_q <= S_LOAD;
				S_LOAD: if (load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= op_t'(req.op);
			key_q <= VALUE_WIDTH'(req.data_value);
		end
	end

	// cell control, gated by the status checks
	always_comb begin
		ctrl            = '0;
		ctrl.compare    = (state_q == S_CMP);
		ctrl.push_front = exec && (op_q == OP_PUSH_FRONT) && !full;
		ctrl.push_back  = exec && (op_q == OP_PUSH_BACK) && !full;
		ctrl.pop_front  = exec && (op_q == OP_POP_FRONT) && !empty;
		ctrl.pop_back   = exec && (op_q == OP_POP_BACK) && !empty;
		ctrl.remove     = exec && (op_q == OP_REMOVE) && !empty;
	end

	// chain ends: key enters at the front, nothing beyond the back
	assign val_w[0]       = key_q;
	assign occ_w[0]       = 1'b1;
	assign val_w[DEPTH+1] = '0;
	assign occ_w[DEPTH+1] = 1'b0;
	assign seen_w[0]      = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dbe_cell #(
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.key         (key_q),
			.left_value  (val_w[i]),
			.left_occ    (occ_w[i]),
			.right_value (val_w[i+2]),
			.right_occ   (occ_w[i+2]),
			.seen_in     (seen_w[i]),
			.value       (val_w[i+1]),
			.occ         (occ_w[i+1]),
			.seen_out    (seen_w[i+1])
		);
	end

	assign found_c = seen_w[DEPTH] && ((op_q == OP_CONTAINS) || (op_q == OP_REMOVE));

	// count, status and found flag of the running op
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= ST_OK;
			found_q  <= 1'b0;
		end else if (exec) begin
			found_q  <= found_c;
			status_q <= ST_OK;
			if ((op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK)) begin
				if (full) status_q <= ST_FULL;
				else      count_q  <= count_q + 1'b1;
			end else if ((op_q == OP_POP_FRONT) || (op_q == OP_POP_BACK)) begin
				if (empty) status_q <= ST_EMPTY;
				else       count_q  <= count_q - 1'b1;
			end else if (op_q == OP_REMOVE) begin
				if (empty)        status_q <= ST_EMPTY;
				else if (found_c) count_q  <= count_q - 1'b1;
			end
		end
	end

	// ends of the deque: cell 0, and the cell whose right neighbor is free
	assign front_c = occ_w[1] ? val_w[1] : '0;

	always_comb begin
		back_c = '0;
		for (int i = 1; i <= DEPTH; i++)
			if (occ_w[i] && !occ_w[i+1])
				back_c = back_c | val_w[i];
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (load)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_status_q <= status_q;
			rsp_found_q  <= found_q;
			rsp_front_q  <= front_c;
			rsp_back_q   <= back_c;
			rsp_count_q  <= count_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.front_value = DATA_W'(rsp_front_q);
	assign rsp.back_value  = DATA_W'(rsp_back_q);
	assign rsp.entry_count = COUNT_W'(rsp_count_q);
	assign rsp.is_empty    = (rsp_count_q == '0);

	// occupied cells always form a solid run from the front of length count
	logic [DEPTH-1:0] occ_vec;
	logic [DEPTH-1:0] occ_exp;
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ_vec[i] = occ_w[i+1];
			occ_exp[i] = (CW'(i) < count_q);
		end
	end

	a_occ_run: assert property (@(posedge clk) disable iff (!arst_n)
		occ_vec == occ_exp)
		else $error("occupancy does not match count");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count beyond depth");

	a_full_nofound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_status_q != ST_OK) |-> !rsp_found_q)
		else $error("found flag on a rejected op");

	a_load_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> (state_q == S_LOAD))
		else $error("readout step skipped");

endmodule

@@ hdl/dbe_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbe_cell
// One slot of the deque. Holds a value and an occupied bit, compares against
// the broadcast key and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
module dbe_cell
	import dbe_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_ctrl_t             ctrl,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [VALUE_WIDTH-1:0] left_value,
	input  logic                   left_occ,
	input  logic [VALUE_WIDTH-1:0] right_value,
	input  logic                   right_occ,
	input  logic                   seen_in,
	output logic [VALUE_WIDTH-1:0] value,
	output logic                   occ,
	output logic                   seen_out
);

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   occ_q;
	logic                   match_q;
	logic                   shift_l;
	logic                   shift_r;
	logic                   fill;

	// first-match chain: set from the matching cell toward the back
	assign seen_out = seen_in | match_q;

	assign shift_r = ctrl.push_front;
	assign shift_l = ctrl.pop_front | (ctrl.remove & seen_out);
	assign fill    = ctrl.push_back & left_occ & ~occ_q;

	// occupancy and match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.compare)
				match_q <= occ_q && (value_q == key);
			priority if (shift_r)
				occ_q <= left_occ;
			else if (shift_l)
				occ_q <= right_occ;
			else if (fill)
				occ_q <= 1'b1;
			else if (ctrl.pop_back)
				occ_q <= occ_q & right_occ;
		end
	end

	// stored value, no reset
	always_ff @(posedge clk) begin
		priority if (shift_r)
			value_q <= left_value;
		else if (shift_l)
			value_q <= right_value;
		else if (fill)
			value_q <= key;
	end

	assign value = value_q;
	assign occ   = occ_q;

endmodule
